// ----- design/sorted_priority_queue_top_macros.svh -----
// Assertion macros for the sorted priority queue.
// Used by sorted_priority_queue_top; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq check failed");
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq check failed");
`else
`define SPQ_ASSERT_SAME(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// No dependencies.
package spq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_QRY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic        [15:0] arrival;
  } entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic   do_enq;
    logic   do_deq;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

// ----- design/spq_cell.sv -----
// One slot of the sorted shift chain.
// Depends on spq_pkg.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  spq_pkg::entry_t   left_q,
  input  logic              left_ins,
  input  spq_pkg::entry_t   right_q,
  output spq_pkg::entry_t   data_q,
  output logic              ins
);
  import spq_pkg::*;

  entry_t data_r;
  entry_t data_nxt;

  // true when the new entry is served before the held one
  function automatic logic goes_before(entry_t a, entry_t b);
    if (a.score != b.score) begin
      return a.score > b.score;
    end
    return a.arrival < b.arrival;
  endfunction

  // empty slots count as "insert here or below"
  assign ins    = !occ || goes_before(ctl.new_entry, data_r);
  assign data_q = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.do_enq && ins) begin
      data_nxt = left_ins ? left_q : ctl.new_entry;
    end else if (ctl.do_deq) begin
      data_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- design/sorted_priority_queue_top.sv -----
// Sorted priority queue: shift chain of QUEUE_DEPTH cells plus count and result register.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_top_macros.svh.
//
// Bounded priority queue, best entry (highest score, then earliest arrival;
// exact duplicates leave in arrival order) always in cell 0. Every cell
// compares the incoming entry with its own and shifts in step with its
// neighbors, so any request - enqueue, dequeue or query - acts at once: one
// request is accepted per clock unless stalled, and its result appears in
// the output register on the next cycle. The cell compare plus the neighbor
// select sets the cycle time. in_stall is raised only while a result waits
// and out_stall is high. Enqueue on full and dequeue on empty report an
// error status and leave the contents unchanged; opcode 3 acts as a query.
module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_opcode,
  input  logic signed [15:0]                   in_new_score,
  input  logic [15:0]                          in_new_arrival,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_out_valid,
  output logic signed [15:0]                   out_out_score,
  output logic [15:0]                          out_out_arrival,
  output logic [1:0]                           out_status,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_entry_count,
  output logic                                 out_now_empty,
  output logic                                 out_now_full
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic          acc;
  op_t           op;
  cell_ctl_t     ctl;
  logic [CW-1:0] count_r, count_nxt;
  status_t       status;

  logic          res_vld_r;
  logic          deq_vld_r;
  entry_t        deq_r;
  status_t       status_r;
  logic [CW-1:0] cnt_out_r;

  entry_t        cell_q [QUEUE_DEPTH];
  logic          ins    [QUEUE_DEPTH];

  assign in_stall = res_vld_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign op       = op_t'(in_opcode);

  always_comb begin
    ctl.do_enq            = 1'b0;
    ctl.do_deq            = 1'b0;
    ctl.new_entry.score   = in_new_score;
    ctl.new_entry.arrival = in_new_arrival;
    count_nxt             = count_r;
    status                = ST_OK;
    case (op)
      OP_ENQ: begin
        if (count_r == FULL_CNT) begin
          status = ST_FULL;
        end else begin
          ctl.do_enq = acc;
          count_nxt  = count_r + 1'b1;
        end
      end
      OP_DEQ: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          ctl.do_deq = acc;
          count_nxt  = count_r - 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic   occ;
      entry_t left_q;
      logic   left_ins;
      entry_t right_q;

      assign occ = CW'(gi) < count_r;

      if (gi == 0) begin : g_head
        assign left_q   = ctl.new_entry;
        assign left_ins = 1'b0;
      end else begin : g_body
        assign left_q   = cell_q[gi-1];
        assign left_ins = ins[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign right_q = cell_q[gi];
      end else begin : g_inner
        assign right_q = cell_q[gi+1];
      end

      spq_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .occ      (occ),
        .left_q   (left_q),
        .left_ins (left_ins),
        .right_q  (right_q),
        .data_q   (cell_q[gi]),
        .ins      (ins[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r   <= count_nxt;
        res_vld_r <= 1'b1;
      end else if (!out_stall) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      deq_vld_r <= ctl.do_deq;
      deq_r     <= ctl.do_deq ? cell_q[0] : '0;
      status_r  <= status;
      cnt_out_r <= count_nxt;
    end
  end

  assign out_valid       = res_vld_r;
  assign out_out_valid   = deq_vld_r;
  assign out_out_score   = deq_r.score;
  assign out_out_arrival = deq_r.arrival;
  assign out_status      = status_r;
  assign out_entry_count = cnt_out_r;
  assign out_now_empty   = cnt_out_r == '0;
  assign out_now_full    = cnt_out_r == FULL_CNT;

`include "sorted_priority_queue_top_macros.svh"

  `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= FULL_CNT)
  `SPQ_ASSERT_NEXT(a_deq_pops, acc && op == OP_DEQ && count_r != '0, out_out_valid && count_r == $past(count_r) - 1'b1)
  `SPQ_ASSERT_NEXT(a_full_holds, acc && op == OP_ENQ && count_r == FULL_CNT, count_r == $past(count_r) && out_status == ST_FULL)
  `SPQ_ASSERT_SAME(a_no_double_op, 1'b1, !(ctl.do_enq && ctl.do_deq))

endmodule

// ----- dv/sorted_priority_queue_checker.sv -----
// Checker for the sorted priority queue: keeps a shadow copy of the sorted store,
// predicts one result per accepted request and compares results in order.
// Depends on spq_pkg.
`timescale 1ns / 100ps

module sorted_priority_queue_checker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic signed [15:0]   in_new_score,
  input  logic [15:0]          in_new_arrival,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_out_valid,
  input  logic signed [15:0]   out_out_score,
  input  logic [15:0]          out_out_arrival,
  input  logic [1:0]           out_status,
  input  logic [CW-1:0]        out_entry_count,
  input  logic                 out_now_empty,
  input  logic                 out_now_full,
  output int                   mismatches,
  output int                   waiting
);
  import spq_pkg::*;

  typedef struct {
    logic               taken;
    logic signed [15:0] score;
    logic [15:0]        arrival;
    logic [1:0]         status;
    logic [CW-1:0]      count;
    logic               empty;
    logic               full;
  } queue_result_t;

  entry_t        shadow_entries[QUEUE_DEPTH];
  int            shadow_count;
  queue_result_t expected_results[$];
  int            mismatch_count;

  // true when the new entry is served ahead of the stored one
  function automatic bit served_ahead(logic signed [15:0] s, logic [15:0] a, entry_t e);
    return (s > $signed(e.score)) || (s == $signed(e.score) && a < e.arrival);
  endfunction

  function automatic queue_result_t apply_request(logic [1:0] op, logic signed [15:0] s,
                                                  logic [15:0] a);
    queue_result_t r;
    int            pos;
    r.taken   = 1'b0;
    r.score   = '0;
    r.arrival = '0;
    r.status  = ST_OK;
    case (op)
      OP_ENQ: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && !served_ahead(s, a, shadow_entries[pos]))
            pos++;
          for (int i = shadow_count; i > pos; i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos].score   = s;
          shadow_entries[pos].arrival = a;
          shadow_count++;
        end
      end
      OP_DEQ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.taken   = 1'b1;
          r.score   = shadow_entries[0].score;
          r.arrival = shadow_entries[0].arrival;
          for (int i = 1; i < shadow_count; i++)
            shadow_entries[i-1] = shadow_entries[i];
          shadow_count--;
        end
      end
      default: ;  // query and the unused code change nothing
    endcase
    r.count = CW'(shadow_count);
    r.empty = (shadow_count == 0);
    r.full  = (shadow_count == QUEUE_DEPTH);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t exp;
    logic          bad;
    if (!rst_n) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      // compare before pushing: a result never belongs to this edge's request
      if (out_valid && !out_stall) begin
        got.taken   = out_out_valid;
        got.score   = out_out_score;
        got.arrival = out_out_arrival;
        got.status  = out_status;
        got.count   = out_entry_count;
        got.empty   = out_now_empty;
        got.full    = out_now_full;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no request pending: valid=%0b score=%0d arrival=%0d",
                     $realtime, got.taken, got.score, got.arrival);
        end else begin
          exp = expected_results.pop_front();
          bad = (got.taken !== exp.taken) || (got.score !== exp.score) ||
                (got.arrival !== exp.arrival) || (got.status !== exp.status) ||
                (got.count !== exp.count) || (got.empty !== exp.empty) ||
                (got.full !== exp.full);
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected valid=%0b score=%0d arrival=%0d status=%0d count=%0d empty=%0b full=%0b",
                       exp.taken, exp.score, exp.arrival, exp.status, exp.count,
                       exp.empty, exp.full);
              $display("  actual   valid=%0b score=%0d arrival=%0d status=%0d count=%0d empty=%0b full=%0b",
                       got.taken, got.score, got.arrival, got.status, got.count,
                       got.empty, got.full);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_request(in_opcode, in_new_score, in_new_arrival));
    end
    mismatches <= mismatch_count;
    waiting    <= expected_results.size();
  end

endmodule

// ----- dv/sorted_priority_queue_top_tb.sv -----
// Testbench top for sorted_priority_queue_top: clock, reset, request and stall
// stimulus, and the verdict. Depends on spq_pkg, sorted_priority_queue_top and sorted_priority_queue_checker.
`timescale 1ns / 100ps

module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int         QUEUE_DEPTH = 16;
  localparam int         CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 60;
  localparam int         PHASE_ITEMS = 217;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_opcode;
  logic signed [15:0]  in_new_score;
  logic [15:0]         in_new_arrival;
  logic                out_valid;
  logic                out_stall;
  logic                out_out_valid;
  logic signed [15:0]  out_out_score;
  logic [15:0]         out_out_arrival;
  logic [1:0]          out_status;
  logic [CW-1:0]       out_entry_count;
  logic                out_now_empty;
  logic                out_now_full;

  int mismatches;
  int waiting;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int enq_bias;
  int bias_left;
  bit hold_req;
  bit hold_off;

  // directed fill: extremes, score ties and exact duplicates
  logic signed [15:0] fill_scores[16] = '{
    16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0000, 16'shffff, 16'sd100, 16'sd100,
    16'sd100,  16'sd100,  16'sd1,    -16'sd2,   16'sh7ffe, 16'sh0000, 16'sh8001, 16'sd5};
  logic [15:0] fill_arrivals[16] = '{
    16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0001, 16'd5, 16'd5,
    16'd4,    16'd6,    16'h0000, 16'd3,    16'hffff, 16'hffff, 16'd2, 16'd5};

  sorted_priority_queue_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_new_score, .in_new_arrival,
    .out_valid, .out_stall, .out_out_valid, .out_out_score, .out_out_arrival,
    .out_status, .out_entry_count, .out_now_empty, .out_now_full
  );

  sorted_priority_queue_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_new_score, .in_new_arrival,
    .out_valid, .out_stall, .out_out_valid, .out_out_score, .out_out_arrival,
    .out_status, .out_entry_count, .out_now_empty, .out_now_full,
    .mismatches, .waiting
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_priority_queue_top verification failed");
      $finish;
    end
  end

  // long receiver hold-off so the output register fills and the input stalls
  initial hold_off = 1'b0;
  always begin
    wait (hold_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
    hold_req = 1'b0;
  end

  initial out_stall = 1'b0;
  always @(negedge clk)
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic [1:0] op, input logic signed [15:0] s,
                          input logic [15:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_new_score   <= s;
    in_new_arrival <= a;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // enqueue/dequeue mix drifts so the count sweeps between empty and full
  task automatic send_random();
    int                 r;
    logic [1:0]         op;
    logic signed [15:0] s;
    logic [15:0]        a;
    if (bias_left == 0) begin
      bias_left = $urandom_range(8, 30);
      case ($urandom_range(2))
        0:       enq_bias = 20;
        1:       enq_bias = 50;
        default: enq_bias = 80;
      endcase
    end
    bias_left--;
    r = $urandom_range(99);
    if (r < 5)                                op = OP_QRY;
    else if (r < 8)                           op = OP_UNUSED;
    else if ($urandom_range(99) < enq_bias)   op = OP_ENQ;
    else                                      op = OP_DEQ;
    case ($urandom_range(9))
      0:       s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1, 2, 3: s = 16'($urandom_range(6)) - 16'd3;  // narrow range forces ties
      default: s = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0:       a = $urandom_range(1) ? 16'hffff : 16'h0000;
      1, 2, 3: a = 16'($urandom_range(3));
      default: a = 16'($urandom);
    endcase
    send_req(op, s, a);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_QRY;
    in_new_score   = '0;
    in_new_arrival = '0;
    hold_req       = 1'b0;
    send_idle_pct  = 22;
    recv_idle_pct  = 46;
    bias_left      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_req(OP_DEQ, 16'sd0, 16'd0);             // dequeue on empty
    send_req(OP_QRY, 16'shffff, 16'hffff);
    send_req(OP_UNUSED, 16'sh7fff, 16'h0000);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_req(OP_ENQ, fill_scores[i], fill_arrivals[i]);
    send_req(OP_ENQ, 16'sd7, 16'd7);             // enqueue on full
    send_req(OP_QRY, 16'sd0, 16'd0);
    repeat (3) send_req(OP_DEQ, 16'sd0, 16'd0);

    for (int phase = 0; phase < 3; phase++) begin
      in_valid <= 1'b0;
      @(posedge clk);
      case (phase)
        0:       begin send_idle_pct = 22; recv_idle_pct = 46; end
        1:       begin send_idle_pct = 46; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      @(negedge clk);
      hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_random();
    end

    in_valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && waiting == 0)
      $display("sorted_priority_queue_top verification clean");
    else
      $display("sorted_priority_queue_top verification failed");
    $finish;
  end

endmodule
